// ===== sv/script_position_classifier_assert.svh =====
// Assertion macros of the port-level checker of the script position classifier.
// Needs nothing but a clock and an active-low reset at each use.
`ifndef SCRIPT_POSITION_CLASSIFIER_ASSERT_SVH
`define SCRIPT_POSITION_CLASSIFIER_ASSERT_SVH

// Same-cycle implication.
`define SPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("spc assertion failed");

// Next-cycle implication.
`define SPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("spc assertion failed");

`endif

// ===== sv/spc_pkg.sv =====
// Types and constants of the script position classifier.
// Used by spc_classify, the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps

package spc_pkg;

	localparam int MAX_CHARS = 32;
	localparam int IDX_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
	localparam int CNT_W = $clog2(MAX_CHARS + 1);

	localparam int BOX_W = 11;
	localparam int CLASS_W = 8;
	localparam int CFG_DATA_W = 8;
	localparam int CHAR_IDX_W = 6;
	localparam int IN_TDATA_W = 40;
	localparam int OUT_TDATA_W = 8;

	localparam logic [7:0] BASELINE_RESET = 8'd64;
	localparam logic signed [11:0] SCRIPT_OFFSET = 12'sd20;
	localparam logic signed [BOX_W-1:0] DROPCAP_BOTTOM = -11'sd128;
	localparam logic signed [BOX_W-1:0] BOX_MIN = {1'b1, {(BOX_W-1){1'b0}}};
	localparam logic signed [BOX_W-1:0] BOX_MAX = 11'sd1023;

	localparam logic REG_CAPS_ONLY = 1'b0;
	localparam logic REG_BASELINE = 1'b1;

	typedef enum logic [1:0] {
		POS_NORMAL  = 2'd0,
		POS_SUB     = 2'd1,
		POS_SUPER   = 2'd2,
		POS_DROPCAP = 2'd3
	} pos_t;

	typedef enum logic [1:0] {
		ST_IN,
		ST_UPD,
		ST_RD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic signed [BOX_W-1:0] top;
		logic signed [BOX_W-1:0] bottom;
	} box_t;

	typedef struct packed {
		logic [CLASS_W-1:0] min_top;
		logic [CLASS_W-1:0] bottom_limit;
	} class_rng_t;

	typedef struct packed {
		logic       caps_only;
		logic [7:0] baseline;
	} cfg_t;

endpackage

// ===== sv/spc_classify.sv =====
// Sorts one merged character box into normal, subscript, superscript or drop cap.
// Depends on spc_pkg.
`timescale 1ns / 1ps

module spc_classify (
	input  spc_pkg::box_t       box,
	input  spc_pkg::class_rng_t rng,
	input  spc_pkg::cfg_t       cfg,
	output spc_pkg::pos_t       pos
);
	import spc_pkg::*;

	logic signed [11:0] top_w;
	logic signed [11:0] bot_w;
	logic signed [11:0] min_top_w;
	logic signed [11:0] max_bot_w;
	logic signed [11:0] base_w;
	pos_t raw;

	assign top_w = {box.top[BOX_W-1], box.top};
	assign bot_w = {box.bottom[BOX_W-1], box.bottom};
	assign min_top_w = $signed({4'b0, rng.min_top});
	assign max_bot_w = $signed({4'b0, rng.bottom_limit});
	assign base_w = $signed({4'b0, cfg.baseline});

	// offsets moved to the box side so that nothing goes below the class range
	always_comb begin
		if (box.bottom <= DROPCAP_BOTTOM) begin
			raw = POS_DROPCAP;
		end else if ((top_w + SCRIPT_OFFSET < min_top_w) &&
				(bot_w + SCRIPT_OFFSET < base_w)) begin
			raw = POS_SUB;
		end else if (bot_w > max_bot_w + SCRIPT_OFFSET) begin
			raw = POS_SUPER;
		end else begin
			raw = POS_NORMAL;
		end
	end

	assign pos = (cfg.caps_only && raw != POS_DROPCAP) ? POS_NORMAL : raw;

endmodule

// ===== sv/script_position_classifier.sv =====
// Top level of the script position classifier: chunk merge, position store, word-end burst.
// Depends on spc_pkg and spc_classify.
//
// channel  | dir | handshake           | payload
// ---------+-----+---------------------+-------------------------------------------------
// s_*      | in  | s_tvalid / s_tready | tdata box and class range, tuser char end, tlast word end
// m_*      | out | m_tvalid / m_tready | tdata char index and position, tlast last of word
// cfg_*    | in  | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
// For each chunk, ST_IN takes the request and ST_UPD merges, classifies and writes the
// position memory. After a word end, each stored character is read from the position
// memory in ST_RD and presented in ST_OUT, where it waits out any output stall.
// Reset clears the counts, the merged box and the registers; the memory needs no clear.
// No chunk is taken while a word is being sent out.
`timescale 1ns / 1ps

module script_position_classifier (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [10:0] chunk_top, [21:11] chunk_bottom, [29:22] class_min_top,
	// [37:30] class_max_bottom, [39:38] zero
	input  logic [spc_pkg::IN_TDATA_W-1:0]     s_tdata,
	// [0] char_end
	input  logic                               s_tuser,
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [5:0] char_index, [7:6] position
	output logic [spc_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                               m_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_index,
	input  logic [spc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import spc_pkg::*;

	state_t state_q, state_d;

	cfg_t cfg_q;

	box_t       box_s1;
	class_rng_t rng_s1;
	logic       cend_s1;
	logic       wend_s1;

	box_t             merged_q;
	box_t             merged;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] sub_q;
	logic [CNT_W-1:0] super_q;
	logic [IDX_W-1:0] idx_q;

	logic [1:0] mem [MAX_CHARS];
	logic [1:0] rd_q;

	pos_t pos;
	logic close;
	logic room;
	logic in_acc;
	logic out_acc;
	logic last_w;
	logic revert;
	pos_t rd_pos;
	pos_t out_pos;

	assign cfg_ready = 1'b1;
	assign in_acc = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.caps_only <= 1'b0;
			cfg_q.baseline <= BASELINE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CAPS_ONLY: cfg_q.caps_only <= cfg_data[0];
				REG_BASELINE:  cfg_q.baseline <= cfg_data;
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	// hold the request for the update cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			box_s1.top <= $signed(s_tdata[10:0]);
			box_s1.bottom <= $signed(s_tdata[21:11]);
			rng_s1.min_top <= s_tdata[29:22];
			rng_s1.bottom_limit <= s_tdata[37:30];
			cend_s1 <= s_tuser;
			wend_s1 <= s_tlast;
		end
	end

	always_comb begin
		merged.top = (box_s1.top > merged_q.top) ? box_s1.top : merged_q.top;
		merged.bottom = (box_s1.bottom < merged_q.bottom) ? box_s1.bottom : merged_q.bottom;
	end

	spc_classify u_classify (
		.box (merged),
		.rng (rng_s1),
		.cfg (cfg_q),
		.pos (pos)
	);

	assign close = cend_s1 || wend_s1;
	assign room = (count_q < CNT_W'(MAX_CHARS));

	always_ff @(posedge clk) begin
		if (state_q == ST_UPD && close && room) begin
			mem[count_q[IDX_W-1:0]] <= pos;
		end
		rd_q <= mem[idx_q];
	end

	assign last_w = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merged_q.top <= BOX_MIN;
			merged_q.bottom <= BOX_MAX;
			count_q <= '0;
			sub_q <= '0;
			super_q <= '0;
			idx_q <= '0;
		end else begin
			if (state_q == ST_UPD) begin
				if (close) begin
					merged_q.top <= BOX_MIN;
					merged_q.bottom <= BOX_MAX;
					if (room) begin
						count_q <= count_q + CNT_W'(1);
						if (pos == POS_SUB) begin
							sub_q <= sub_q + CNT_W'(1);
						end
						if (pos == POS_SUPER) begin
							super_q <= super_q + CNT_W'(1);
						end
					end
				end else begin
					merged_q <= merged;
				end
			end
			if (out_acc) begin
				if (last_w) begin
					count_q <= '0;
					sub_q <= '0;
					super_q <= '0;
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IN:   if (in_acc) state_d = ST_UPD;
			ST_UPD:  state_d = wend_s1 ? ST_RD : ST_IN;
			ST_RD:   state_d = ST_OUT;
			ST_OUT:  if (out_acc) state_d = last_w ? ST_IN : ST_RD;
			default: state_d = ST_IN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_IN:   s_tready = 1'b1;
			ST_OUT:  m_tvalid = 1'b1;
			default: begin
				s_tready = 1'b0;
				m_tvalid = 1'b0;
			end
		endcase
	end

	// drop sub and super when either of them makes up more than three quarters of the word
	assign revert = ({(CNT_W+2)'(sub_q)} << 2) > ((CNT_W+2)'(count_q) * (CNT_W+2)'(3)) ||
			({(CNT_W+2)'(super_q)} << 2) > ((CNT_W+2)'(count_q) * (CNT_W+2)'(3));
	assign rd_pos = pos_t'(rd_q);
	assign out_pos = (revert && (rd_pos == POS_SUB || rd_pos == POS_SUPER)) ? POS_NORMAL
			: rd_pos;

	assign m_tdata = {out_pos, CHAR_IDX_W'(idx_q)};
	assign m_tlast = last_w;

endmodule

// ===== sv/spc_checker.sv =====
// Port-level checks of the script position classifier, bound to the top level.
// Depends on script_position_classifier_assert.svh.
`timescale 1ns / 1ps
`include "script_position_classifier_assert.svh"

module spc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	`SPC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	`SPC_ASSERT_NOW(a_no_in_during_out, clk, arst_n, m_tvalid, !s_tready)
	`SPC_ASSERT_NEXT(a_word_starts_at_zero, clk, arst_n, s_tvalid && s_tready && s_tlast, ##2 (m_tvalid && m_tdata[5:0] == 6'd0))
	`SPC_ASSERT_NEXT(a_index_advances, clk, arst_n, m_tvalid && m_tready && !m_tlast, ##1 (m_tvalid && m_tdata[5:0] == $past(m_tdata[5:0], 2) + 6'd1))

endmodule

bind script_position_classifier spc_checker u_spc_checker (.*);

// ===== test/spc_position_checker.sv =====
// Checker for the script position classifier: watches the chunk, result and register channels,
// predicts the positions of each word and compares them with the results. Depends on spc_pkg.
`timescale 1ns / 1ps

module spc_position_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [spc_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            s_tuser,
	input  logic                            s_tlast,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [spc_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            m_tlast,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [spc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              errors,
	output int                              pending
);
	import spc_pkg::*;

	typedef struct {
		logic [CHAR_IDX_W-1:0] char_index;
		pos_t                  position;
		logic                  last;
	} char_position_t;

	char_position_t positions_due[$];
	char_position_t want;
	pos_t word_positions[MAX_CHARS];
	pos_t pos;
	logic signed [BOX_W-1:0] box_top, box_bottom, chunk_top, chunk_bottom;
	logic [CLASS_W-1:0] min_top, bottom_limit;
	int char_count, sub_count, super_count;
	logic caps_only, revert;
	logic [7:0] baseline;

	function automatic pos_t classify_char(input logic signed [BOX_W-1:0] top, bottom,
			input logic [CLASS_W-1:0] lo_top, hi_bottom, input logic [7:0] base);
		int t, b, offset;
		t = top;
		b = bottom;
		offset = int'(SCRIPT_OFFSET);
		if (b <= int'(DROPCAP_BOTTOM))
			return POS_DROPCAP;
		if (t < int'(lo_top) - offset && b < int'(base) - offset)
			return POS_SUB;
		if (b > int'(hi_bottom) + offset)
			return POS_SUPER;
		return POS_NORMAL;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			positions_due.delete();
			box_top = BOX_MIN;
			box_bottom = BOX_MAX;
			char_count = 0;
			sub_count = 0;
			super_count = 0;
			caps_only = 1'b0;
			baseline = BASELINE_RESET;
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_CAPS_ONLY)
					caps_only = cfg_data[0];
				else
					baseline = cfg_data;
			end

			// Results are compared before this cycle's chunk can add new ones.
			if (m_tvalid && m_tready) begin
				if (positions_due.size() == 0) begin
					errors++;
					$error("result with no position due: char_index %0d position %0d",
						m_tdata[CHAR_IDX_W-1:0], m_tdata[OUT_TDATA_W-1:CHAR_IDX_W]);
				end else begin
					want = positions_due.pop_front();
					if (m_tdata[CHAR_IDX_W-1:0] !== want.char_index) begin
						errors++;
						$error("char_index: expected %0d, actual %0d",
							want.char_index, m_tdata[CHAR_IDX_W-1:0]);
					end
					if (m_tdata[OUT_TDATA_W-1:CHAR_IDX_W] !== want.position) begin
						errors++;
						$error("position: expected %0d, actual %0d",
							want.position, m_tdata[OUT_TDATA_W-1:CHAR_IDX_W]);
					end
					if (m_tlast !== want.last) begin
						errors++;
						$error("last: expected %0d, actual %0d", want.last, m_tlast);
					end
				end
			end

			if (s_tvalid && s_tready) begin
				chunk_top = s_tdata[BOX_W-1:0];
				chunk_bottom = s_tdata[2*BOX_W-1:BOX_W];
				min_top = s_tdata[2*BOX_W+CLASS_W-1:2*BOX_W];
				bottom_limit = s_tdata[2*BOX_W+2*CLASS_W-1:2*BOX_W+CLASS_W];
				if (chunk_top > box_top)
					box_top = chunk_top;
				if (chunk_bottom < box_bottom)
					box_bottom = chunk_bottom;
				// A word end closes the character even without a char end.
				if (s_tuser || s_tlast) begin
					pos = classify_char(box_top, box_bottom, min_top, bottom_limit, baseline);
					if (caps_only && pos != POS_DROPCAP)
						pos = POS_NORMAL;
					// Characters past the store depth are dropped.
					if (char_count < MAX_CHARS) begin
						word_positions[char_count] = pos;
						char_count++;
						if (pos == POS_SUB)
							sub_count++;
						else if (pos == POS_SUPER)
							super_count++;
					end
					box_top = BOX_MIN;
					box_bottom = BOX_MAX;
					if (s_tlast) begin
						// More than three quarters sub or super: all sub and super revert to normal.
						revert = (4 * sub_count > 3 * char_count) ||
							(4 * super_count > 3 * char_count);
						for (int i = 0; i < char_count; i++) begin
							want.char_index = CHAR_IDX_W'(i);
							want.position = word_positions[i];
							if (revert && (want.position == POS_SUB ||
									want.position == POS_SUPER))
								want.position = POS_NORMAL;
							want.last = (i + 1 == char_count);
							positions_due.insert(positions_due.size(), want);
						end
						char_count = 0;
						sub_count = 0;
						super_count = 0;
					end
				end
			end
			pending = positions_due.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Testbench top of the script position classifier: clock, reset, chunk words, register writes,
// random stalls on both sides and the verdict. Depends on spc_pkg and spc_position_checker.
`timescale 1ns / 1ps

module tb_top;
	import spc_pkg::*;

	localparam int CHUNK_TARGET = 460;
	localparam int PHASES = 6;
	localparam int SETTLE_CYCLES = 12;
	localparam int WATCHDOG_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = REG_CAPS_ONLY;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count;
	int positions_pending;
	int chunks_sent = 0;
	int ready_hold = 0;
	int idle_cycles = 0;
	bit pressure = 1'b1;
	logic [7:0] baseline_now = BASELINE_RESET;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	script_position_classifier i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	spc_position_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.errors   (fail_count),
		.pending  (positions_pending)
	);

	// Mostly no pause or a short one, now and then a long one.
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (!pressure) begin
			m_tready <= 1'b1;
		end else if ($urandom_range(0, 2) == 0) begin
			m_tready <= 1'b0;
			ready_hold <= pause_len();
		end else begin
			m_tready <= 1'b1;
			ready_hold <= $urandom_range(0, 12);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL script_position_classifier");
			$finish;
		end
	end

	task automatic send_chunk(input logic signed [BOX_W-1:0] top, bottom,
			input logic [CLASS_W-1:0] min_top, bottom_limit, input logic cend, wend);
		int gap;
		gap = pressure ? pause_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, bottom_limit, min_top, bottom, top};
		s_tuser <= cend;
		s_tlast <= wend;
		do @(posedge clk); while (!s_tready);
		chunks_sent++;
	endtask

	// Drop valid, wait for the last result, then let the block settle.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (positions_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic index, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (index == REG_BASELINE)
			baseline_now = value;
		@(posedge clk);
	endtask

	// Aim one character at a position; normal means a box of random noise.
	task automatic send_char(input pos_t aim, input logic ends_word);
		int tv, bv, chunks;
		logic [CLASS_W-1:0] min_top, bottom_limit;
		logic signed [BOX_W-1:0] top, bottom;
		min_top = CLASS_W'($urandom_range(0, 255));
		bottom_limit = CLASS_W'($urandom_range(0, 255));
		top = BOX_W'($urandom);
		bottom = BOX_W'($urandom);
		case (aim)
			POS_DROPCAP: begin
				bottom = BOX_W'(-int'($urandom_range(128, 1024)));
			end
			POS_SUB: begin
				top = BOX_W'(-1024 + int'($urandom_range(0, int'(min_top) - 21 + 1024)));
				bottom = BOX_W'(-127 +
					int'($urandom_range(0, int'(baseline_now) - 21 + 127)));
			end
			POS_SUPER: begin
				bottom = BOX_W'(int'(bottom_limit) + 21 +
					int'($urandom_range(0, 1023 - int'(bottom_limit) - 21)));
			end
			default: ;
		endcase
		chunks = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
		repeat (chunks) begin
			if ($urandom_range(0, 3) == 0) begin
				tv = $signed(BOX_W'($urandom));
				bv = $signed(BOX_W'($urandom));
			end else begin
				tv = int'(top) - int'($urandom_range(0, 60));
				bv = int'(bottom) + int'($urandom_range(0, 60));
				if (tv < -1024)
					tv = -1024;
				if (bv > 1023)
					bv = 1023;
			end
			send_chunk(BOX_W'(tv), BOX_W'(bv), CLASS_W'($urandom), CLASS_W'($urandom),
				1'b0, 1'b0);
		end
		send_chunk(top, bottom, min_top, bottom_limit,
			ends_word ? ($urandom_range(0, 3) != 0) : 1'b1, ends_word);
	endtask

	task automatic send_word();
		int nchars;
		bit biased;
		pos_t favored;
		nchars = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
		biased = ($urandom_range(0, 2) != 0);
		favored = pos_t'($urandom_range(0, 3));
		for (int c = 0; c < nchars; c++) begin
			if (biased && $urandom_range(0, 4) != 0)
				send_char(favored, c == nchars - 1);
			else
				send_char(pos_t'($urandom_range(0, 3)), c == nchars - 1);
		end
	endtask

	initial begin
		int directed;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes of the box and class fields in a one-character word.
		send_chunk(BOX_MAX, BOX_MIN, 8'd255, 8'd255, 1'b1, 1'b1);

		// Normal over two chunks, where only the closing chunk's class counts;
		// then subscript, superscript, and a drop cap on the boundary closed by word end alone.
		send_chunk(11'sd50, 11'sd10, 8'd255, 8'd255, 1'b0, 1'b0);
		send_chunk(11'sd60, 11'sd5, 8'd40, 8'd80, 1'b1, 1'b0);
		send_chunk(-11'sd600, -11'sd100, 8'd255, 8'd255, 1'b1, 1'b0);
		send_chunk(11'sd1000, 11'sd300, 8'd0, 8'd0, 1'b1, 1'b0);
		send_chunk(BOX_MIN, -11'sd128, 8'd255, 8'd255, 1'b0, 1'b1);

		// All subscripts: they revert.
		repeat (3) send_chunk(-11'sd500, -11'sd60, 8'd100, 8'd200, 1'b1, 1'b0);
		send_chunk(-11'sd500, -11'sd60, 8'd100, 8'd200, 1'b1, 1'b1);

		// Exactly three quarters subscripts: they stay.
		repeat (3) send_chunk(-11'sd500, -11'sd60, 8'd100, 8'd200, 1'b1, 1'b0);
		send_chunk(11'sd100, 11'sd50, 8'd100, 8'd100, 1'b1, 1'b1);

		// Small caps with the lowest baseline: only the drop cap survives.
		wait_idle();
		write_reg(REG_CAPS_ONLY, 8'd1);
		write_reg(REG_BASELINE, 8'd0);
		send_chunk(BOX_MIN, -11'sd50, 8'd255, 8'd255, 1'b1, 1'b0);
		send_chunk(11'sd500, 11'sd400, 8'd0, 8'd10, 1'b1, 1'b0);
		send_chunk(11'sd0, -11'sd300, 8'd0, 8'd0, 1'b1, 1'b1);

		directed = chunks_sent;
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase)
				0: begin
					write_reg(REG_CAPS_ONLY, 8'd1);
					write_reg(REG_BASELINE, 8'd255);
				end
				1: begin
					write_reg(REG_CAPS_ONLY, 8'd0);
					write_reg(REG_BASELINE, 8'd0);
				end
				2: begin
					write_reg(REG_CAPS_ONLY, 8'd0);
					write_reg(REG_BASELINE, 8'd255);
				end
				default: begin
					write_reg(REG_CAPS_ONLY, ($urandom_range(0, 3) == 0) ? 8'd1 : 8'd0);
					write_reg(REG_BASELINE, CFG_DATA_W'($urandom_range(0, 255)));
				end
			endcase
			// One phase runs with neither side pausing.
			pressure = (phase != 3);
			while (chunks_sent < directed + (phase + 1) * (CHUNK_TARGET - directed) / PHASES)
				send_word();
		end

		pressure = 1'b1;
		wait_idle();
		if (fail_count == 0 && positions_pending == 0)
			$display("PASS script_position_classifier");
		else
			$display("FAIL script_position_classifier");
		$finish;
	end

endmodule
